>>> sv/stol_pkg.sv
// ----------------------------------------------------------------------------
// stol_pkg
// Shared constants, codes and types of the segment table offset lookup unit.
// ----------------------------------------------------------------------------
package stol_pkg;

	localparam int MAX_SEGMENTS = 64;

	localparam int ADDR_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int TOTAL_W = $clog2(MAX_SEGMENTS + 1);
	localparam int SEL_W   = 6;
	localparam int CMP_W   = (TOTAL_W > SEL_W) ? TOTAL_W : SEL_W;
	localparam int COUNT_W = 31;
	localparam int INDEX_W = 40;
	localparam int SPAN_W  = COUNT_W + 1;
	localparam int END_W   = INDEX_W + 1;
	localparam int ENTRY_W = 2 * COUNT_W;

	typedef logic [1:0] op_t;
	localparam op_t OP_APPEND      = 2'd0;
	localparam op_t OP_LOCATE_DATA = 2'd1;
	localparam op_t OP_LOCATE_COMB = 2'd2;
	localparam op_t OP_READ        = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK     = 3'd0;
	localparam status_t ST_EMPTY  = 3'd1;
	localparam status_t ST_BEYOND = 3'd2;
	localparam status_t ST_FULL   = 3'd3;
	localparam status_t ST_BADSEL = 3'd4;

	typedef struct packed {
		logic [SEL_W-1:0]   segment_number;
		logic [COUNT_W-1:0] offset_in_segment;
		logic [COUNT_W-1:0] data_count_out;
		logic [COUNT_W-1:0] calib_count_out;
		status_t            status;
	} res_t;

endpackage

>>> sv/stol_in_if.sv
// ----------------------------------------------------------------------------
// stol_in_if
// Request channel: valid/ready handshake with one operation per transaction.
// ----------------------------------------------------------------------------
interface stol_in_if;
	import stol_pkg::*;

	logic               valid;
	logic               ready;
	op_t                operation;
	logic [COUNT_W-1:0] data_count;
	logic [COUNT_W-1:0] calib_count;
	logic [INDEX_W-1:0] global_index;
	logic [SEL_W-1:0]   segment_select;

	modport source (
		output valid, operation, data_count, calib_count, global_index, segment_select,
		input  ready
	);

	modport sink (
		input  valid, operation, data_count, calib_count, global_index, segment_select,
		output ready
	);

endinterface

>>> sv/stol_out_if.sv
// ----------------------------------------------------------------------------
// stol_out_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
interface stol_out_if;
	import stol_pkg::*;

	logic               valid;
	logic               ready;
	logic [SEL_W-1:0]   segment_number;
	logic [COUNT_W-1:0] offset_in_segment;
	logic [COUNT_W-1:0] data_count_out;
	logic [COUNT_W-1:0] calib_count_out;
	status_t            status;

	modport source (
		output valid, segment_number, offset_in_segment, data_count_out,
		calib_count_out, status,
		input  ready
	);

	modport sink (
		input  valid, segment_number, offset_in_segment, data_count_out,
		calib_count_out, status,
		output ready
	);

endinterface

>>> sv/stol_ram.sv
// ----------------------------------------------------------------------------
// stol_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stol_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 64,
	parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/stol_ctrl.sv
// ----------------------------------------------------------------------------
// stol_ctrl
// Operation sequencer: appends segments, walks the segment memory one entry
// per cycle for locates, and reads single entries.
// ----------------------------------------------------------------------------
module stol_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	stol_in_if.sink                  in_ch,
	output stol_pkg::res_t           res,
	output logic                     res_valid,
	input  logic                     res_take,
	output logic                     wr_en,
	output logic [stol_pkg::ADDR_W-1:0]  wr_addr,
	output logic [stol_pkg::ENTRY_W-1:0] wr_data,
	output logic [stol_pkg::ADDR_W-1:0]  rd_addr,
	input  logic [stol_pkg::ENTRY_W-1:0] rd_data
);
	import stol_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_RDDATA = 2'd2;
	localparam logic [1:0] S_PEND   = 2'd3;

	logic [1:0]         state_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic [INDEX_W-1:0] base_q;
	logic [INDEX_W-1:0] idx_q;
	logic               combined_q;
	res_t               res_q;

	logic               accept;
	logic               full;
	logic [COUNT_W-1:0] rd_dc;
	logic [COUNT_W-1:0] rd_cc;
	logic [SPAN_W-1:0]  span;
	logic [END_W-1:0]   seg_end;
	logic               hit;
	logic               last;
	logic [INDEX_W-1:0] offset;
	res_t               res_new;

	assign accept    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign full      = (total_q == TOTAL_W'(MAX_SEGMENTS));

	assign rd_dc = rd_data[ENTRY_W-1:COUNT_W];
	assign rd_cc = rd_data[COUNT_W-1:0];

	// span of the entry that arrives from memory this cycle
	assign span    = {1'b0, rd_dc} + (combined_q ? {1'b0, rd_cc} : SPAN_W'(0));
	assign seg_end = {1'b0, base_q} + END_W'(span);
	assign hit     = ({1'b0, idx_q} < seg_end);
	assign last    = ((TOTAL_W'(ptr_q) + TOTAL_W'(1)) == total_q);
	assign offset  = idx_q - base_q;

	// appends write at the accept edge; the next walk or read starts only after the
	// sequencer has left the pending state for idle, so no write/read overlap on an entry can occur
	assign wr_en   = accept && (in_ch.operation == OP_APPEND) && !full;
	assign wr_addr = ADDR_W'(total_q);
	assign wr_data = {in_ch.data_count, in_ch.calib_count};

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = (in_ch.operation == OP_READ) ? ADDR_W'(in_ch.segment_select) : '0;
		end else begin
			rd_addr = ptr_q + ADDR_W'(1);
		end
	end

	assign res       = res_q;
	assign res_valid = (state_q == S_PEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_ch.operation)
							OP_APPEND: begin
								state_q <= S_PEND;
								if (!full) begin
									total_q <= total_q + TOTAL_W'(1);
								end
							end
							OP_LOCATE_DATA, OP_LOCATE_COMB: begin
								state_q <= (total_q == '0) ? S_PEND : S_WALK;
							end
							OP_READ: begin
								if (CMP_W'(in_ch.segment_select) >= CMP_W'(total_q)) begin
									state_q <= S_PEND;
								end else begin
									state_q <= S_RDDATA;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_WALK: begin
					if (hit || last) begin
						state_q <= S_PEND;
					end
				end
				S_RDDATA: state_q <= S_PEND;
				S_PEND: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		res_new = '0;
		unique case (state_q)
			S_IDLE: begin
				unique case (in_ch.operation)
					OP_APPEND: begin
						if (full) begin
							res_new.status = ST_FULL;
						end else begin
							res_new.segment_number = SEL_W'(total_q);
						end
					end
					OP_LOCATE_DATA, OP_LOCATE_COMB: res_new.status = ST_EMPTY;
					OP_READ:                        res_new.status = ST_BADSEL;
					default:                        res_new.status = ST_OK;
				endcase
			end
			S_WALK: begin
				if (hit) begin
					res_new.segment_number = SEL_W'(ptr_q);
					if (!combined_q) begin
						res_new.offset_in_segment = offset[COUNT_W-1:0];
					end
				end else begin
					res_new.status = ST_BEYOND;
				end
			end
			S_RDDATA: begin
				res_new.data_count_out  = rd_dc;
				res_new.calib_count_out = rd_cc;
			end
			default: res_new = res_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			res_q      <= res_new;
			ptr_q      <= '0;
			base_q     <= '0;
			idx_q      <= in_ch.global_index;
			combined_q <= (in_ch.operation == OP_LOCATE_COMB);
		end else if (state_q == S_WALK) begin
			res_q  <= res_new;
			ptr_q  <= ptr_q + ADDR_W'(1);
			base_q <= seg_end[INDEX_W-1:0];
		end else if (state_q == S_RDDATA) begin
			res_q <= res_new;
		end
	end

endmodule

>>> sv/segment_table_offset_lookup_unit.sv
// ----------------------------------------------------------------------------
// segment_table_offset_lookup_unit
// Append-only segment table with data index / combined id lookup and reads.
// ----------------------------------------------------------------------------
// results: append, full, empty and bad-select go from accept to the pending
//   state and then the output register, a read via the RAM read state, a locate via
//   the walk; one operation in flight, the next is taken once the result has
//   moved to the output register, for a locate after the walk over the segment
//   memory's single read port, one entry per cycle
// reset: table empty, entry contents undefined until appended, no clear pass
module segment_table_offset_lookup_unit (
	input  logic       clk,
	input  logic       arst_n,
	stol_in_if.sink    in_ch,
	stol_out_if.source out_ch
);
	import stol_pkg::*;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0]  rd_data;
	res_t                res;
	logic                res_valid;
	logic                res_take;
	logic                out_valid_q;
	res_t                out_q;

	stol_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (MAX_SEGMENTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	stol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// output register lets the sequencer move on while a result waits
	assign res_take = res_valid && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.segment_number    = out_q.segment_number;
	assign out_ch.offset_in_segment = out_q.offset_in_segment;
	assign out_ch.data_count_out    = out_q.data_count_out;
	assign out_ch.calib_count_out   = out_q.calib_count_out;
	assign out_ch.status            = out_q.status;

endmodule

>>> sim/stol_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stol_lookup_checker
// Watches the request and result channels of the lookup unit, keeps its own
// copy of the segment table and compares every result with the oldest
// expected one, field by field.
// ----------------------------------------------------------------------------
module stol_lookup_checker (
	input  logic clk,
	input  logic arst_n,
	stol_in_if   req_mon,
	stol_out_if  rsp_mon,
	output int   mismatch_count,
	output int   results_pending
);
	import stol_pkg::*;

	logic [COUNT_W-1:0] tbl_data  [MAX_SEGMENTS];
	logic [COUNT_W-1:0] tbl_calib [MAX_SEGMENTS];
	int                 tbl_used;
	res_t               expected_results [$];
	int                 result_seq;

	function automatic res_t predict_lookup(input op_t op,
			input logic [COUNT_W-1:0] dc, input logic [COUNT_W-1:0] cc,
			input logic [INDEX_W-1:0] gi, input logic [SEL_W-1:0] sel);
		res_t             r;
		logic [END_W:0]   base;
		logic [END_W:0]   span;
		bit               hit;
		r = '0;
		base = '0;
		hit = 1'b0;
		case (op)
			OP_APPEND: begin
				if (tbl_used >= MAX_SEGMENTS) begin
					r.status = ST_FULL;
				end else begin
					tbl_data[tbl_used] = dc;
					tbl_calib[tbl_used] = cc;
					r.segment_number = tbl_used[SEL_W-1:0];
					tbl_used++;
				end
			end
			OP_LOCATE_DATA, OP_LOCATE_COMB: begin
				if (tbl_used == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// first segment whose span covers the index, zero spans fall through
					for (int s = 0; s < tbl_used; s++) begin
						if (!hit) begin
							span = tbl_data[s];
							if (op == OP_LOCATE_COMB)
								span = span + tbl_calib[s];
							if (gi < base + span) begin
								hit = 1'b1;
								r.segment_number = s[SEL_W-1:0];
								if (op == OP_LOCATE_DATA)
									r.offset_in_segment = COUNT_W'(gi - base);
							end
							base = base + span;
						end
					end
					if (!hit)
						r.status = ST_BEYOND;
				end
			end
			default: begin
				if (int'(sel) >= tbl_used) begin
					r.status = ST_BADSEL;
				end else begin
					r.data_count_out = tbl_data[sel];
					r.calib_count_out = tbl_calib[sel];
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		res_t exp_r;
		bit   bad;
		if (arst_n) begin
			// result side first: a result always belongs to an earlier request
			if (rsp_mon.valid && rsp_mon.ready) begin
				result_seq++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d arrived with nothing expected", result_seq);
				end else begin
					exp_r = expected_results.pop_front();
					bad = (rsp_mon.segment_number !== exp_r.segment_number) ||
						(rsp_mon.offset_in_segment !== exp_r.offset_in_segment) ||
						(rsp_mon.data_count_out !== exp_r.data_count_out) ||
						(rsp_mon.calib_count_out !== exp_r.calib_count_out) ||
						(rsp_mon.status !== exp_r.status);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("result %0d mismatch (expected/actual): seg %0d/%0d ",
								result_seq,
								exp_r.segment_number, rsp_mon.segment_number);
							$write("off %0d/%0d data %0d/%0d ",
								exp_r.offset_in_segment, rsp_mon.offset_in_segment,
								exp_r.data_count_out, rsp_mon.data_count_out);
							$display("calib %0d/%0d status %0d/%0d",
								exp_r.calib_count_out, rsp_mon.calib_count_out,
								exp_r.status, rsp_mon.status);
						end
					end
				end
			end
			if (req_mon.valid && req_mon.ready)
				expected_results.insert(expected_results.size(),
					predict_lookup(req_mon.operation,
					req_mon.data_count, req_mon.calib_count, req_mon.global_index,
					req_mon.segment_select));
			results_pending = expected_results.size();
		end
	end

endmodule

>>> sim/tb_segment_table_offset_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_table_offset_lookup_unit
// Drives append, locate and read requests into the lookup unit with random
// gaps and back pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_segment_table_offset_lookup_unit;
	import stol_pkg::*;

	localparam int RANDOM_ITEMS   = 2000;
	localparam int HOLD_START     = 2500;
	localparam int HOLD_CYCLES    = 300;
	localparam int CALM_RX_START  = 10000;
	localparam int CALM_RX_END    = 16000;
	localparam int CALM_TX_START  = 1200;
	localparam int CALM_TX_END    = 1500;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   results_pending;
	int   idle_cycles;
	int   rx_cycle;
	bit   gaps_on;

	// what the sender has appended so far, used only to aim the indices
	logic [COUNT_W-1:0] app_data  [MAX_SEGMENTS];
	logic [COUNT_W-1:0] app_calib [MAX_SEGMENTS];
	int                 app_count;

	stol_in_if  req_ch ();
	stol_out_if rsp_ch ();

	segment_table_offset_lookup_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (rsp_ch)
	);

	stol_lookup_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_mon         (req_ch),
		.rsp_mon         (rsp_ch),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [COUNT_W-1:0] rand_count();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10) return '0;
		if (pick < 20) return '1;
		if (pick < 30) return COUNT_W'(1);
		if (pick < 70) return COUNT_W'($urandom_range(100, 1));
		return COUNT_W'($urandom);
	endfunction

	task automatic send_item(input op_t op, input logic [COUNT_W-1:0] dc,
			input logic [COUNT_W-1:0] cc, input logic [INDEX_W-1:0] gi,
			input logic [SEL_W-1:0] sel);
		if (gaps_on) begin
			while ($urandom_range(99) < 12) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid          <= 1'b1;
		req_ch.operation      <= op;
		req_ch.data_count     <= dc;
		req_ch.calib_count    <= cc;
		req_ch.global_index   <= gi;
		req_ch.segment_select <= sel;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (op == OP_APPEND && app_count < MAX_SEGMENTS) begin
			app_data[app_count] = dc;
			app_calib[app_count] = cc;
			app_count++;
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
		@(posedge clk);
	endtask

	// result side: random stalls, one long hold-off, one calm window
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
				rsp_ch.ready <= 1'b0;
			else if (rx_cycle >= CALM_RX_START && rx_cycle < CALM_RX_END)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(99) >= 12);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned        r;
		op_t                op;
		logic [INDEX_W-1:0] gi;
		logic [SEL_W-1:0]   sel;
		logic [END_W:0]     total;
		logic [END_W:0]     bound;
		int                 k;
		bit                 comb;
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.operation      = OP_APPEND;
		req_ch.data_count     = '0;
		req_ch.calib_count    = '0;
		req_ch.global_index   = '0;
		req_ch.segment_select = '0;
		gaps_on               = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_item(OP_LOCATE_DATA, '0, '0, '0, '0);
		send_item(OP_LOCATE_COMB, '0, '0, '1, '0);
		send_item(OP_READ, '0, '0, '0, 6'd0);
		send_item(OP_READ, '0, '0, '0, 6'd63);
		// zero span first, a calib-only segment and a segment of maximum counts
		send_item(OP_APPEND, 31'd0, 31'd0, '0, '0);
		send_item(OP_APPEND, 31'd5, 31'd3, '0, '0);
		send_item(OP_APPEND, 31'd0, 31'd4, '0, '0);
		send_item(OP_APPEND, 31'h7FFFFFFF, 31'h7FFFFFFF, '0, '0);
		send_item(OP_APPEND, 31'd1, 31'd0, '0, '0);
		send_item(OP_LOCATE_DATA, '0, '0, 40'd0, '0);
		send_item(OP_LOCATE_DATA, '0, '0, 40'd4, '0);
		send_item(OP_LOCATE_DATA, '0, '0, 40'd5, '0);
		send_item(OP_LOCATE_DATA, '0, '0, 40'h80000004, '0);
		send_item(OP_LOCATE_DATA, '0, '0, 40'h80000005, '0);
		send_item(OP_LOCATE_COMB, '0, '0, 40'd7, '0);
		send_item(OP_LOCATE_COMB, '0, '0, 40'd8, '0);
		send_item(OP_LOCATE_COMB, '0, '0, 40'd12, '0);
		send_item(OP_LOCATE_COMB, '0, '0, 40'h10000000A, '0);
		send_item(OP_LOCATE_COMB, '0, '0, 40'h10000000B, '0);
		send_item(OP_LOCATE_COMB, '0, '0, 40'hFFFFFFFFFF, '0);
		send_item(OP_READ, '0, '0, '0, 6'd3);
		send_item(OP_READ, '0, '0, '0, 6'd0);
		send_item(OP_READ, '0, '0, '0, 6'd2);
		send_item(OP_READ, '0, '0, '0, 6'd5);
		send_item(OP_READ, '0, '0, '0, 6'd63);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			gaps_on = !(n >= CALM_TX_START && n < CALM_TX_END);
			r = $urandom_range(99);
			if (r < 6)
				op = OP_APPEND;
			else if (r < 41)
				op = OP_LOCATE_DATA;
			else if (r < 76)
				op = OP_LOCATE_COMB;
			else
				op = OP_READ;

			// aim the index inside, at segment edges, at the total or anywhere
			comb = (op == OP_LOCATE_COMB);
			total = '0;
			bound = '0;
			k = $urandom_range(app_count);
			for (int s = 0; s < app_count; s++) begin
				if (s == k) bound = total;
				total = total + app_data[s] + (comb ? app_calib[s] : '0);
			end
			if (k == app_count) bound = total;
			r = $urandom_range(99);
			if (r < 40 && total != 0)
				gi = INDEX_W'({$urandom, $urandom} % total);
			else if (r < 70)
				gi = INDEX_W'(bound + $urandom_range(2) - 1);
			else if (r < 82)
				gi = INDEX_W'(total + $urandom_range(2) - 1);
			else
				gi = INDEX_W'({$urandom, $urandom});

			if ($urandom_range(99) < 80 && app_count > 0)
				sel = SEL_W'($urandom_range(app_count - 1));
			else
				sel = SEL_W'($urandom_range(63));

			send_item(op, rand_count(), rand_count(), gi, sel);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && results_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
